@@ rtl/q2e_pkg.sv @@
package q2e_pkg;

	localparam int CORDIC_STEPS_DEF = 16;

	// quotient and square-root digit count (values up to 2^30)
	localparam int QW = 31;
	// atan2 operand width, CORDIC datapath width, angle accumulator width
	localparam int OPW = 35;
	localparam int CW = 58;
	localparam int ZW = 34;
	localparam int AW = 36;
	localparam int PRESHIFT = 20;
	localparam int OUT_LIMIT = 25736;

	typedef logic signed [OPW-1:0] opnd_t;
	typedef logic signed [ZW-1:0] ang_t;

	localparam ang_t ANG_PI = 34'sd1686629713;

	// atan(2^-t) in Q3.29, rounded to nearest
	localparam ang_t ATAN_TAB [24] = '{
		34'sd421657428, 34'sd248918915, 34'sd131521918, 34'sd66762579,
		34'sd33510843, 34'sd16771758, 34'sd8387925, 34'sd4194219,
		34'sd2097141, 34'sd1048575, 34'sd524288, 34'sd262144,
		34'sd131072, 34'sd65536, 34'sd32768, 34'sd16384,
		34'sd8192, 34'sd4096, 34'sd2048, 34'sd1024,
		34'sd512, 34'sd256, 34'sd128, 34'sd64
	};

	// Q3.29 to Q4.12: round half up, then clamp
	function automatic logic [15:0] to_q412(input logic signed [AW-1:0] a);
		logic signed [AW-1:0] r;
		begin
			r = (a + AW'(65536)) >>> 17;
			if (r > AW'(OUT_LIMIT))
				return 16'(OUT_LIMIT);
			else if (r < AW'(-OUT_LIMIT))
				return 16'(-OUT_LIMIT);
			else
				return r[15:0];
		end
	endfunction

endpackage

@@ rtl/quaternion_to_euler.sv @@
// Channel | Direction | Handshake            | Payload
// s_*     | in        | s_tvalid / s_tready  | s_tdata: comp_i, comp_j, comp_k, comp_r
// m_*     | out       | m_tvalid / m_tready  | m_tdata: angle_x, angle_y, angle_z;
//         |           |                      | m_tuser: near_singular
// cfg_*   | in        | cfg_valid / cfg_ready| cfg_data: axis_order
//
// One transaction enters per cycle unless a stall at m_tready holds the pipeline; its stages include the
// 31-stage restoring divider, the 31-stage square root and the CORDIC stages.
// Every stage holds a valid bit; a stage advances when it is empty or the next one
// advances, so bubbles collapse and a stall at m_tready loses nothing.
// arst_n clears all valid bits and axis_order; data registers are not reset.
// axis_order travels with each transaction from the cycle it is accepted.
module quaternion_to_euler
	import q2e_pkg::*;
#(
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // comp_i, comp_j, comp_k, comp_r
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // angle_x, angle_y, angle_z
	output logic [0:0]  m_tuser,   // near_singular
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_data   // axis_order
);

	// stage map
	localparam int ST_DIV = 3;
	localparam int ST_SQ  = ST_DIV + QW;
	localparam int ST_RT  = ST_SQ + 1;
	localparam int ST_COR = ST_RT + QW;
	localparam int ST_OUT = ST_COR + CORDIC_STEPS + 1;
	localparam int NST    = ST_OUT + 1;

	typedef struct packed {
		logic ord;
		logic zero;
		logic locked;
	} flag_t;

	typedef struct packed {
		flag_t fl;
		logic  msign;
		opnd_t ya;
		opnd_t xa;
		opnd_t yb;
		opnd_t xb;
	} side_t;

	logic           axis_order_q;
	logic [NST-1:0] vld_q;
	logic [NST-1:0] en;

	// configuration: always ready, take the low bit
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_order_q <= 1'b0;
		end else if (cfg_valid) begin
			axis_order_q <= cfg_data[0];
		end
	end

	// advance chain: a stage moves when empty or when its successor moves
	assign en[NST-1] = !vld_q[NST-1] || m_tready;
	for (genvar k = 0; k < NST - 1; k++) begin : g_en
		assign en[k] = !vld_q[k] || en[k+1];
	end

	assign s_tready = en[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0])
				vld_q[0] <= s_tvalid;
			for (int k = 1; k < NST; k++) begin
				if (en[k])
					vld_q[k] <= vld_q[k-1];
			end
		end
	end

	// ---------------- stage 1: products (Q4.28)
	logic signed [15:0] qi, qj, qk, qr;
	logic signed [31:0] rr_s1, ii_s1, jj_s1, kk_s1, ri_s1, jk_s1;
	logic signed [31:0] ij_s1, rk_s1, ik_s1, jr_s1;
	logic signed [15:0] qi_s1, qr_s1;
	logic               ord_s1;

	assign qi = s_tdata[15:0];
	assign qj = s_tdata[31:16];
	assign qk = s_tdata[47:32];
	assign qr = s_tdata[63:48];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			rr_s1  <= qr * qr;
			ii_s1  <= qi * qi;
			jj_s1  <= qj * qj;
			kk_s1  <= qk * qk;
			ri_s1  <= qr * qi;
			jk_s1  <= qj * qk;
			ij_s1  <= qi * qj;
			rk_s1  <= qr * qk;
			ik_s1  <= qi * qk;
			jr_s1  <= qj * qr;
			qi_s1  <= qi;
			qr_s1  <= qr;
			ord_s1 <= axis_order_q;
		end
	end

	// ---------------- stage 2: norm, middle term, cross terms
	opnd_t       n_w, m_w, c1_w, c2_w, c3_w, d1_w, d2_w, d3_w, mag_w;
	logic [32:0] n_s2, mag_s2;
	side_t       sd_s2;
	logic signed [15:0] qi_s2, qr_s2;

	always_comb begin
		n_w   = OPW'(rr_s1) + OPW'(ii_s1) + OPW'(jj_s1) + OPW'(kk_s1);
		m_w   = (OPW'(ri_s1) - OPW'(jk_s1)) <<< 1;
		mag_w = m_w[OPW-1] ? -m_w : m_w;
		c1_w  = (OPW'(jk_s1) + OPW'(ri_s1)) <<< 1;
		c2_w  = (OPW'(ik_s1) + OPW'(jr_s1)) <<< 1;
		c3_w  = (OPW'(ij_s1) + OPW'(rk_s1)) <<< 1;
		d1_w  = OPW'(rr_s1) - OPW'(ii_s1) - OPW'(jj_s1) + OPW'(kk_s1);
		d2_w  = OPW'(rr_s1) + OPW'(ii_s1) - OPW'(jj_s1) - OPW'(kk_s1);
		d3_w  = OPW'(rr_s1) - OPW'(ii_s1) + OPW'(jj_s1) - OPW'(kk_s1);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			n_s2             <= n_w[32:0];
			mag_s2           <= mag_w[32:0];
			sd_s2.fl.ord     <= ord_s1;
			sd_s2.fl.zero    <= (n_w == '0);
			sd_s2.fl.locked  <= 1'b0;
			sd_s2.msign      <= m_w[OPW-1];
			sd_s2.ya         <= ord_s1 ? c2_w : c1_w;
			sd_s2.xa         <= d1_w;
			sd_s2.yb         <= c3_w;
			sd_s2.xb         <= ord_s1 ? d3_w : d2_w;
			qi_s2            <= qi_s1;
			qr_s2            <= qr_s1;
		end
	end

	// ---------------- stage 3: gimbal-lock test, free-angle operand select
	logic [43:0] mag1000, n999;
	logic        lock_w;
	side_t       sd3_w;
	logic [32:0] n_s3, mag_s3;
	side_t       sd_s3;

	always_comb begin
		mag1000 = (44'(mag_s2) << 10) - (44'(mag_s2) << 4) - (44'(mag_s2) << 3);
		n999    = (44'(n_s2) << 10) - (44'(n_s2) << 4) - (44'(n_s2) << 3) - 44'(n_s2);
		lock_w  = mag1000 > n999;
		// locked: the free angle comes from atan2(i, r)
		sd3_w           = sd_s2;
		sd3_w.fl.locked = lock_w;
		if (lock_w) begin
			sd3_w.ya = OPW'(qi_s2);
			sd3_w.xa = OPW'(qr_s2);
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			n_s3   <= n_s2;
			mag_s3 <= mag_s2;
			sd_s3  <= sd3_w;
		end
	end

	// ---------------- divider: s = floor(mag * 2^30 / n), one quotient bit a stage
	logic [33:0]   div_rem_s [QW];
	logic [QW-1:0] div_q_s   [QW];
	logic [32:0]   div_n_s   [QW];
	side_t         div_sd_s  [QW];

	for (genvar d = 0; d < QW; d++) begin : g_div
		logic [33:0]   part;
		logic [QW-1:0] qin;
		logic [32:0]   nin;
		logic          ge;

		if (d == 0) begin : g_first
			assign part = {1'b0, mag_s3};
			assign qin  = '0;
			assign nin  = n_s3;
			always_ff @(posedge clk) begin
				if (en[ST_DIV])
					div_sd_s[0] <= sd_s3;
			end
		end else begin : g_rest
			assign part = {div_rem_s[d-1][32:0], 1'b0};
			assign qin  = div_q_s[d-1];
			assign nin  = div_n_s[d-1];
			always_ff @(posedge clk) begin
				if (en[ST_DIV+d])
					div_sd_s[d] <= div_sd_s[d-1];
			end
		end

		assign ge = part >= {1'b0, nin};

		always_ff @(posedge clk) begin
			if (en[ST_DIV+d]) begin
				div_n_s[d]   <= nin;
				div_rem_s[d] <= ge ? part - {1'b0, nin} : part;
				div_q_s[d]   <= qin | (QW'(ge) << (QW - 1 - d));
			end
		end
	end

	// ---------------- square: v = 2^60 - s*s
	logic [60:0]   sq_v_s;
	logic [QW-1:0] sq_s_s;
	side_t         sq_sd_s;

	always_ff @(posedge clk) begin
		if (en[ST_SQ]) begin
			sq_v_s  <= 61'(62'h1000_0000_0000_0000 - 62'(div_q_s[QW-1]) * 62'(div_q_s[QW-1]));
			sq_s_s  <= div_q_s[QW-1];
			sq_sd_s <= div_sd_s[QW-1];
		end
	end

	// ---------------- square root: c = floor(sqrt(v)), one root bit a stage
	logic [60:0]   rt_rem_s [QW];
	logic [QW-1:0] rt_res_s [QW];
	logic [QW-1:0] rt_s_s   [QW];
	side_t         rt_sd_s  [QW];

	for (genvar d = 0; d < QW; d++) begin : g_rt
		localparam int B = QW - 1 - d;
		logic [60:0]   rin;
		logic [QW-1:0] resin;
		logic [61:0]   trial;
		logic          ge;

		if (d == 0) begin : g_first
			assign rin   = sq_v_s;
			assign resin = '0;
			always_ff @(posedge clk) begin
				if (en[ST_RT]) begin
					rt_s_s[0]  <= sq_s_s;
					rt_sd_s[0] <= sq_sd_s;
				end
			end
		end else begin : g_rest
			assign rin   = rt_rem_s[d-1];
			assign resin = rt_res_s[d-1];
			always_ff @(posedge clk) begin
				if (en[ST_RT+d]) begin
					rt_s_s[d]  <= rt_s_s[d-1];
					rt_sd_s[d] <= rt_sd_s[d-1];
				end
			end
		end

		assign trial = (62'(resin) << (B + 1)) + (62'd1 << (2 * B));
		assign ge    = {1'b0, rin} >= trial;

		always_ff @(posedge clk) begin
			if (en[ST_RT+d]) begin
				rt_rem_s[d] <= ge ? 61'({1'b0, rin} - trial) : rin;
				rt_res_s[d] <= resin | (QW'(ge) << B);
			end
		end
	end

	// ---------------- three CORDIC units in step
	opnd_t sm_y, sm_x;
	ang_t  zm, za, zb;
	flag_t fl_s [CORDIC_STEPS+1];

	assign sm_y = rt_sd_s[QW-1].msign ? -OPW'(rt_s_s[QW-1]) : OPW'(rt_s_s[QW-1]);
	assign sm_x = OPW'(rt_res_s[QW-1]);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cor_mid (
		.clk   (clk),
		.en    (en[ST_COR +: CORDIC_STEPS + 1]),
		.y_in  (sm_y),
		.x_in  (sm_x),
		.z_out (zm)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cor_a (
		.clk   (clk),
		.en    (en[ST_COR +: CORDIC_STEPS + 1]),
		.y_in  (rt_sd_s[QW-1].ya),
		.x_in  (rt_sd_s[QW-1].xa),
		.z_out (za)
	);

	q2e_cordic #(.STEPS(CORDIC_STEPS)) u_cor_b (
		.clk   (clk),
		.en    (en[ST_COR +: CORDIC_STEPS + 1]),
		.y_in  (rt_sd_s[QW-1].yb),
		.x_in  (rt_sd_s[QW-1].xb),
		.z_out (zb)
	);

	always_ff @(posedge clk) begin
		if (en[ST_COR])
			fl_s[0] <= rt_sd_s[QW-1].fl;
		for (int i = 1; i <= CORDIC_STEPS; i++) begin
			if (en[ST_COR+i])
				fl_s[i] <= fl_s[i-1];
		end
	end

	// ---------------- output register: order swap, rounding, clamp, zero-norm clear
	flag_t                fo;
	logic signed [AW-1:0] a1, a2, am;
	logic [15:0]          a1_o, a2_o, am_o;
	logic [47:0]          out_data_s;
	logic                 out_flag_s;

	assign fo   = fl_s[CORDIC_STEPS];
	assign a1   = fo.locked ? (AW'(za) <<< 1) : AW'(za);
	assign a2   = fo.locked ? '0 : AW'(zb);
	assign am   = AW'(zm);
	assign a1_o = to_q412(a1);
	assign a2_o = to_q412(a2);
	assign am_o = to_q412(am);

	always_ff @(posedge clk) begin
		if (en[ST_OUT]) begin
			if (fo.zero) begin
				out_data_s <= '0;
				out_flag_s <= 1'b0;
			end else begin
				out_data_s <= fo.ord ? {a2_o, a1_o, am_o} : {a2_o, am_o, a1_o};
				out_flag_s <= fo.locked;
			end
		end
	end

	assign m_tvalid   = vld_q[NST-1];
	assign m_tdata    = out_data_s;
	assign m_tuser[0] = out_flag_s;

	// ---------------- checks
	a_lock_zero_z : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[47:32] == 16'd0)
		else $error("locked result with nonzero last angle");

	a_ready_when_drained : assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked while output stage empty");

	a_angle_range : assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $signed(m_tdata[15:0]) <= OUT_LIMIT
			&& $signed(m_tdata[15:0]) >= -OUT_LIMIT
			&& $signed(m_tdata[31:16]) <= OUT_LIMIT
			&& $signed(m_tdata[31:16]) >= -OUT_LIMIT)
		else $error("angle out of range");

endmodule

@@ rtl/q2e_cordic.sv @@
module q2e_cordic
	import q2e_pkg::*;
#(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input  logic         clk,
	input  logic [STEPS:0] en,
	input  opnd_t        y_in,
	input  opnd_t        x_in,
	output ang_t         z_out
);

	localparam int EXT = CW - OPW - PRESHIFT;

	logic signed [CW-1:0] cx_s [STEPS+1];
	logic signed [CW-1:0] cy_s [STEPS+1];
	ang_t                 cz_s [STEPS+1];
	logic                 cf_s [STEPS+1];

	logic signed [CW-1:0] xe, ye;

	assign xe = {{EXT{x_in[OPW-1]}}, x_in, PRESHIFT'(0)};
	assign ye = {{EXT{y_in[OPW-1]}}, y_in, PRESHIFT'(0)};

	// turn the vector into the right half-plane
	always_ff @(posedge clk) begin
		if (en[0]) begin
			cf_s[0] <= (x_in == '0) && (y_in == '0);
			if (xe[CW-1]) begin
				cx_s[0] <= -xe;
				cy_s[0] <= -ye;
				cz_s[0] <= ye[CW-1] ? -ANG_PI : ANG_PI;
			end else begin
				cx_s[0] <= xe;
				cy_s[0] <= ye;
				cz_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en[i+1]) begin
				cf_s[i+1] <= cf_s[i];
				if (!cy_s[i][CW-1] && cy_s[i] != '0) begin
					cx_s[i+1] <= cx_s[i] + (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] - (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] + ATAN_TAB[i];
				end else begin
					cx_s[i+1] <= cx_s[i] - (cy_s[i] >>> i);
					cy_s[i+1] <= cy_s[i] + (cx_s[i] >>> i);
					cz_s[i+1] <= cz_s[i] - ATAN_TAB[i];
				end
			end
		end
	end

	// both operands zero: no angle
	assign z_out = cf_s[STEPS] ? '0 : cz_s[STEPS];

endmodule
